// File: rtl/tss_pkg.sv
// shared types, constants and character class functions for the text segment splitter
`default_nettype none
package tss_pkg;

   localparam int unsigned UNIT_WIDTH = 16;
   localparam int unsigned CFG_WIDTH = 16;
   localparam logic [CFG_WIDTH-1:0] DEFAULT_LIMIT = 16'd300;

   localparam logic [UNIT_WIDTH-1:0] HIRAGANA_LO = 16'h3040;
   localparam logic [UNIT_WIDTH-1:0] KATAKANA_HI = 16'h30FF;
   localparam logic [UNIT_WIDTH-1:0] HANGUL_LO = 16'hAC00;
   localparam logic [UNIT_WIDTH-1:0] HANGUL_HI = 16'hD7AF;
   localparam logic [UNIT_WIDTH-1:0] CJK_EXT_A_LO = 16'h3400;
   localparam logic [UNIT_WIDTH-1:0] CJK_EXT_A_HI = 16'h4DBF;
   localparam logic [UNIT_WIDTH-1:0] CJK_UNIFIED_LO = 16'h4E00;
   localparam logic [UNIT_WIDTH-1:0] CJK_UNIFIED_HI = 16'h9FFF;
   localparam logic [UNIT_WIDTH-1:0] CJK_COMPAT_LO = 16'hF900;
   localparam logic [UNIT_WIDTH-1:0] CJK_COMPAT_HI = 16'hFAFF;

   typedef struct packed {
      logic                  text_end;
      logic                  segment_end;
      logic [UNIT_WIDTH-1:0] out_unit;
   } result_type;

   function automatic logic is_cjk(input logic [UNIT_WIDTH-1:0] c);
      return (c >= HIRAGANA_LO && c <= KATAKANA_HI) || (c >= HANGUL_LO && c <= HANGUL_HI)
          || (c >= CJK_EXT_A_LO && c <= CJK_EXT_A_HI)
          || (c >= CJK_UNIFIED_LO && c <= CJK_UNIFIED_HI)
          || (c >= CJK_COMPAT_LO && c <= CJK_COMPAT_HI);
   endfunction

   function automatic logic is_terminator(input logic [UNIT_WIDTH-1:0] c);
      return c == 16'h002E || c == 16'h0021 || c == 16'h003F || c == 16'h003B
          || c == 16'h3002 || c == 16'hFF01 || c == 16'hFF1F || c == 16'h2026
          || c == 16'hFF1B;
   endfunction

   function automatic logic is_space(input logic [UNIT_WIDTH-1:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085
          || c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A)
          || c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F
          || c == 16'h3000;
   endfunction

endpackage
`default_nettype wire

// File: rtl/text_segment_splitter.sv
// text segment splitter: one code unit look-ahead with segment boundary marking
// output: a unit's transaction leaves once its successor (or end of text) has been taken,
// the earliest result shows on rsp in the cycle after that acceptance
// throughput: one unit per cycle; the final unit of a text adds one result slot, absorbed
// by the four-entry result queue which takes a unit whenever two entries are free
// reset: synchronous, empties the queue, drops the held unit, clears the length, limit 300
`default_nettype none
module text_segment_splitter #(
   parameter int unsigned LENGTH_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [tss_pkg::CFG_WIDTH-1:0]      csr_data,    // max_segment_chars
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [tss_pkg::UNIT_WIDTH-1:0]     req_tdata,   // code_unit
   input  wire                                req_tlast,   // last_of_text
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tss_pkg::UNIT_WIDTH-1:0]     rsp_tdata,   // out_unit
   output logic                               rsp_tuser,   // segment_end
   output logic                               rsp_tlast    // text_end
);
   import tss_pkg::*;

   localparam int unsigned CMP_WIDTH = (LENGTH_WIDTH > CFG_WIDTH) ? LENGTH_WIDTH : CFG_WIDTH;
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   logic [CFG_WIDTH-1:0]    limit_ff, limit_in;
   logic [UNIT_WIDTH-1:0]   held_unit_ff, held_unit_in;
   logic                    held_valid_ff, held_valid_in;
   logic [LENGTH_WIDTH-1:0] seg_len_ff, seg_len_in;

   result_type              queue_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   logic                    req_accept, rsp_accept;
   logic [LENGTH_WIDTH-1:0] len_inc;
   logic [CFG_WIDTH-1:0]    limit_eff;
   logic                    held_end;
   result_type              held_res, new_res, first_res;
   logic [1:0]              push_cnt;

   assign csr_ready = 1'b1;
   assign req_tready = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   assign rsp_tdata = queue_ff[rd_ptr_ff].out_unit;
   assign rsp_tuser = queue_ff[rd_ptr_ff].segment_end;
   assign rsp_tlast = queue_ff[rd_ptr_ff].text_end;

   always_comb begin
      len_inc = (seg_len_ff == '1) ? seg_len_ff : seg_len_ff + 1'b1;
      limit_eff = (limit_ff == '0) ? DEFAULT_LIMIT : limit_ff;
      held_end = (is_terminator(held_unit_ff)
                  && (is_cjk(req_tdata) || is_space(req_tdata)))
               || is_space(held_unit_ff)
               || (CMP_WIDTH'(len_inc) >= CMP_WIDTH'(limit_eff));
      held_res.out_unit = held_unit_ff;
      held_res.segment_end = held_end;
      held_res.text_end = 1'b0;
      new_res.out_unit = req_tdata;
      new_res.segment_end = 1'b1;
      new_res.text_end = 1'b1;
      first_res = held_valid_ff ? held_res : new_res;
      push_cnt = 2'(held_valid_ff) + 2'(req_tlast);
   end

   always_comb begin
      limit_in = csr_valid ? csr_data : limit_ff;
      held_unit_in = held_unit_ff;
      held_valid_in = held_valid_ff;
      seg_len_in = seg_len_ff;
      if (req_accept) begin
         held_unit_in = req_tdata;
         held_valid_in = !req_tlast;
         if (req_tlast) begin
            seg_len_in = '0;
         end else if (held_valid_ff) begin
            seg_len_in = held_end ? '0 : len_inc;
         end
      end
      wr_ptr_in = req_accept ? wr_ptr_ff + QPTR_W'(push_cnt) : wr_ptr_ff;
      rd_ptr_in = rsp_accept ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (req_accept ? QCNT_W'(push_cnt) : '0)
               - QCNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= DEFAULT_LIMIT;
         held_valid_ff <= 1'b0;
         held_unit_ff <= '0;
         seg_len_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         held_valid_ff <= held_valid_in;
         held_unit_ff <= held_unit_in;
         seg_len_ff <= seg_len_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (req_accept && push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= new_res;
      end
   end

endmodule
`default_nettype wire

// File: test/text_segment_splitter_tb.sv
// self-checking testbench for the text segment splitter with a look-ahead segment predictor
module text_segment_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tss_pkg::*;

   localparam int unsigned SEG_LEN_WIDTH = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [UNIT_WIDTH-1:0] STOP_UNITS [9] = '{
      16'h002E, 16'h0021, 16'h003F, 16'h003B, 16'h3002,
      16'hFF01, 16'hFF1F, 16'h2026, 16'hFF1B
   };
   localparam logic [UNIT_WIDTH-1:0] LONE_BLANKS [9] = '{
      16'h0020, 16'h0085, 16'h00A0, 16'h1680, 16'h2028,
      16'h2029, 16'h202F, 16'h205F, 16'h3000
   };
   localparam logic [UNIT_WIDTH-1:0] CJK_LOW [5] = '{
      HIRAGANA_LO, HANGUL_LO, CJK_EXT_A_LO, CJK_UNIFIED_LO, CJK_COMPAT_LO
   };
   localparam logic [UNIT_WIDTH-1:0] CJK_HIGH [5] = '{
      KATAKANA_HI, HANGUL_HI, CJK_EXT_A_HI, CJK_UNIFIED_HI, CJK_COMPAT_HI
   };
   localparam logic [UNIT_WIDTH-1:0] CLASS_EDGES [20] = '{
      16'h303F, 16'h3100, 16'hABFF, 16'hD7B0, 16'h33FF,
      16'h4DC0, 16'h4DFF, 16'hA000, 16'hF8FF, 16'hFB00,
      16'h0008, 16'h000E, 16'h001F, 16'h0084, 16'h0086,
      16'h1FFF, 16'h200B, 16'h2027, 16'h302F, 16'h3001
   };

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE
   } ready_mode_t;

   typedef struct {
      logic [UNIT_WIDTH-1:0] unit;
      logic                  last;
   } text_item_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_WIDTH-1:0]  csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [UNIT_WIDTH-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [UNIT_WIDTH-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   text_item_t pending_units[$];
   result_type expected_units[$];

   int units_queued = 0;
   int units_taken = 0;
   int limit_writes = 0;
   int failures = 0;
   int idle_cycles = 0;
   int burst_left = 1;
   int gap_left = 0;
   int ready_span = 0;
   logic req_taken = 1'b0;
   ready_mode_t ready_mode = READY_ALWAYS;

   // predictor state
   logic [CFG_WIDTH-1:0]     seg_limit = DEFAULT_LIMIT;
   logic [UNIT_WIDTH-1:0]    lookahead_unit = '0;
   logic                     lookahead_full = 1'b0;
   logic [SEG_LEN_WIDTH-1:0] seg_length = '0;

   text_segment_splitter #(
      .LENGTH_WIDTH(SEG_LEN_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic unit_is_cjk(input logic [UNIT_WIDTH-1:0] c);
      return (c >= 16'h3040 && c <= 16'h30FF) || (c >= 16'hAC00 && c <= 16'hD7AF)
          || (c >= 16'h3400 && c <= 16'h4DBF) || (c >= 16'h4E00 && c <= 16'h9FFF)
          || (c >= 16'hF900 && c <= 16'hFAFF);
   endfunction

   function automatic logic unit_is_stop(input logic [UNIT_WIDTH-1:0] c);
      logic hit;
      hit = 1'b0;
      foreach (STOP_UNITS[i])
         if (c == STOP_UNITS[i])
            hit = 1'b1;
      return hit;
   endfunction

   function automatic logic unit_is_blank(input logic [UNIT_WIDTH-1:0] c);
      logic hit;
      hit = (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h2000 && c <= 16'h200A);
      foreach (LONE_BLANKS[i])
         if (c == LONE_BLANKS[i])
            hit = 1'b1;
      return hit;
   endfunction

   // judge one unit against its successor and queue the marked unit
   task automatic mark_unit(input logic [UNIT_WIDTH-1:0] unit, input logic at_end,
                            input logic [UNIT_WIDTH-1:0] next);
      logic [SEG_LEN_WIDTH-1:0] length;
      logic [CFG_WIDTH-1:0]     bound;
      logic                     boundary;
      result_type               marked;
      bound = (seg_limit == '0) ? DEFAULT_LIMIT : seg_limit;
      length = seg_length;
      if (length != '1)
         length = length + 1'b1;
      boundary = at_end || unit_is_blank(unit) || (32'(length) >= 32'(bound))
              || (unit_is_stop(unit) && (unit_is_cjk(next) || unit_is_blank(next)));
      seg_length = boundary ? '0 : length;
      marked.out_unit = unit;
      marked.segment_end = boundary;
      marked.text_end = at_end;
      expected_units.push_back(marked);
   endtask

   task automatic split_unit(input logic [UNIT_WIDTH-1:0] unit, input logic last);
      if (lookahead_full)
         mark_unit(lookahead_unit, 1'b0, unit);
      if (last) begin
         mark_unit(unit, 1'b1, '0);
         lookahead_full = 1'b0;
         lookahead_unit = '0;
         seg_length = '0;
      end else begin
         lookahead_unit = unit;
         lookahead_full = 1'b1;
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      text_item_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_units.size() != 0) begin
            item = pending_units.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.unit;
            req_tlast <= item.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_mode_t'($urandom_range(0, 2));
         ready_span = $urandom_range(8, 64);
      end else begin
         ready_span = ready_span - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // monitor: check results first, then predict from the inputs taken at this edge
   always @(posedge clock) begin
      result_type want;
      logic moved;
      moved = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (expected_units.size() == 0) begin
               $error("unexpected result transaction: unit %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_units.pop_front();
               if (rsp_tdata !== want.out_unit) begin
                  $error("out_unit mismatch: expected %h, actual %h", want.out_unit, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser !== want.segment_end) begin
                  $error("segment_end mismatch: expected %b, actual %b (unit %h)",
                         want.segment_end, rsp_tuser, want.out_unit);
                  failures++;
               end
               if (rsp_tlast !== want.text_end) begin
                  $error("text_end mismatch: expected %b, actual %b (unit %h)",
                         want.text_end, rsp_tlast, want.out_unit);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            seg_limit = csr_data;
            limit_writes++;
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            split_unit(req_tdata, req_tlast);
            units_taken++;
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_unit(input logic [UNIT_WIDTH-1:0] unit, input logic last);
      text_item_t item;
      item.unit = unit;
      item.last = last;
      pending_units.push_back(item);
      units_queued++;
   endtask

   task automatic queue_text(input logic [UNIT_WIDTH-1:0] units[$]);
      foreach (units[i])
         push_unit(units[i], i == units.size() - 1);
   endtask

   function automatic logic [UNIT_WIDTH-1:0] pick_unit();
      int roll;
      int idx;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         return 16'($urandom_range(16'h0041, 16'h007A));
      if (roll < 45)
         return STOP_UNITS[$urandom_range(0, 8)];
      if (roll < 60) begin
         idx = $urandom_range(0, 4);
         return 16'($urandom_range(CJK_LOW[idx], CJK_HIGH[idx]));
      end
      if (roll < 72) begin
         idx = $urandom_range(0, 2);
         if (idx == 0)
            return 16'($urandom_range(16'h0009, 16'h000D));
         if (idx == 1)
            return 16'($urandom_range(16'h2000, 16'h200A));
         return LONE_BLANKS[$urandom_range(0, 8)];
      end
      if (roll < 80)
         return CLASS_EDGES[$urandom_range(0, 19)];
      if (roll < 85)
         return 16'($urandom_range(16'hD800, 16'hDFFF));
      return 16'($urandom());
   endfunction

   task automatic queue_random_texts(input int target);
      int count;
      int length;
      count = 0;
      while (count < target) begin
         length = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
         for (int i = 0; i < length; i++)
            push_unit(pick_unit(), i == length - 1);
         count += length;
      end
   endtask

   // a run of plain letters that only the length limit can split
   task automatic queue_letter_text(input int length);
      for (int i = 0; i < length; i++)
         push_unit(16'($urandom_range(16'h0041, 16'h005A)), i == length - 1);
   endtask

   task automatic settle();
      while (units_taken != units_queued || expected_units.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_WIDTH-1:0] value);
      int writes_seen;
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      writes_seen = limit_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      while (limit_writes == writes_seen)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [UNIT_WIDTH-1:0] chars[$];
      logic [CFG_WIDTH-1:0] limits[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-unit texts
      chars = '{16'h0041};
      queue_text(chars);
      chars = '{16'hFFFF};
      queue_text(chars);
      // stop before cjk, stop before blank, blank, stop at end of text
      chars = '{16'h002E, 16'h4E00, 16'h3002, 16'h0020, 16'hFF01};
      queue_text(chars);
      // stop before a letter, surrogate, ellipsis before ideographic space
      chars = '{16'h0021, 16'h0041, 16'h003F, 16'hD800, 16'h2026, 16'h3000,
                16'hFFFF, 16'h0000};
      queue_text(chars);
      chars = '{16'hFF1F, 16'hF900, 16'hFF1B, 16'hFAFF, 16'h003B, 16'h0009,
                16'h000D, 16'h00A0};
      queue_text(chars);
      queue_random_texts(120);

      limits = '{16'd1, 16'd0, 16'hFFFF, DEFAULT_LIMIT, 16'd2,
                 16'($urandom_range(3, 60))};
      foreach (limits[p]) begin
         write_limit(limits[p]);
         if (limits[p] == '0)
            queue_letter_text(310);
         if (limits[p] == DEFAULT_LIMIT) begin
            // hold the sender mid-text until every pending result is out
            for (int i = 0; i < 10; i++)
               push_unit(pick_unit(), 1'b0);
            settle();
            push_unit(16'h002E, 1'b1);
         end
         queue_random_texts(40);
      end

      settle();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tss_pkg.sv
rtl/text_segment_splitter.sv
test/text_segment_splitter_tb.sv
